/* hw/rtl/pcs_pkg.sv */
`timescale 1ns / 1ps

package pcs_pkg;

	localparam int PIX_W = 8;
	localparam int CFG_IDX_W = 8;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int QUO_W = PIX_W;
	localparam int PROD_W = 2 * PIX_W;
	localparam int REM_W = PROD_W + 1;
	localparam int DEN_W = PIX_W + 1;

	localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;

	localparam logic [CFG_IDX_W-1:0] REG_IN_LOW = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IN_HIGH = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_LOW = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_HIGH = 8'd3;

	// Classified pixel: segment base, slope magnitude and sign, offset and span.
	typedef struct packed {
		logic [PIX_W-1:0] lo;
		logic             neg;
		logic [PIX_W-1:0] dm;
		logic [PIX_W-1:0] pa;
		logic [PIX_W-1:0] d;
	} item_t;

endpackage

/* hw/rtl/pcs_front.sv */
`timescale 1ns / 1ps

module pcs_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pcs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pcs_pkg::PIX_W-1:0]       cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [pcs_pkg::PIX_W-1:0]       s_tdata,
	output logic                            push,
	output pcs_pkg::item_t                  push_item,
	input  logic                            queue_full
);
	import pcs_pkg::*;

	logic [PIX_W-1:0] in_low_q;
	logic [PIX_W-1:0] in_high_q;
	logic [PIX_W-1:0] out_low_q;
	logic [PIX_W-1:0] out_high_q;
	logic             item_v_q;
	item_t            item_q;
	item_t            cls;
	logic [PIX_W-1:0] hi;
	logic [PIX_W-1:0] a;
	logic             s_acc;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_low_q <= '0;
			in_high_q <= FULL_SCALE;
			out_low_q <= '0;
			out_high_q <= FULL_SCALE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_IN_LOW: in_low_q <= cfg_data;
				REG_IN_HIGH: in_high_q <= cfg_data;
				REG_OUT_LOW: out_low_q <= cfg_data;
				REG_OUT_HIGH: out_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (s_tdata < in_low_q) begin
			cls.lo = '0;
			hi = out_low_q;
			a = '0;
			cls.d = in_low_q;
		end else if (s_tdata <= in_high_q) begin
			cls.lo = out_low_q;
			hi = out_high_q;
			a = in_low_q;
			cls.d = in_high_q - in_low_q;
		end else begin
			cls.lo = out_high_q;
			hi = FULL_SCALE;
			a = in_high_q;
			cls.d = FULL_SCALE - in_high_q;
		end
		cls.neg = hi < cls.lo;
		cls.dm = cls.neg ? (cls.lo - hi) : (hi - cls.lo);
		cls.pa = s_tdata - a;
	end

	assign s_tready = !item_v_q || !queue_full;
	assign s_acc = s_tvalid && s_tready;
	assign push = item_v_q && !queue_full;
	assign push_item = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_q <= 1'b0;
		end else if (s_acc) begin
			item_v_q <= 1'b1;
		end else if (push) begin
			item_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			item_q <= cls;
		end
	end

endmodule

/* hw/rtl/pcs_queue.sv */
`timescale 1ns / 1ps

module pcs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pcs_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output pcs_pkg::item_t pop_item
);
	import pcs_pkg::*;

	item_t                  mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] cnt_q;
	logic                   do_push;
	logic                   do_pop;

	assign full = cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* hw/rtl/pcs_back.sv */
`timescale 1ns / 1ps

module pcs_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      queue_empty,
	input  pcs_pkg::item_t            pop_item,
	output logic                      pop,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [pcs_pkg::PIX_W-1:0] m_tdata
);
	import pcs_pkg::*;

	typedef struct packed {
		logic [PIX_W-1:0]  lo;
		logic              neg;
		logic [PIX_W-1:0]  d;
		logic [PROD_W-1:0] m;
	} prod_t;

	typedef struct packed {
		logic [PIX_W-1:0] lo;
		logic             flat;
		logic             qneg;
		logic [REM_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [QUO_W-1:0] quo;
	} div_t;

	logic             en;
	logic             prod_v_s1;
	prod_t            prod_s1;
	logic             div_v [QUO_W+1];
	div_t             div_s [QUO_W+1];
	div_t             prep;
	logic [REM_W-1:0] two_m;
	logic [REM_W-1:0] d_ext;
	logic             out_v_q;
	logic [PIX_W-1:0] out_q;
	div_t             last;

	// The whole back pipeline moves together whenever the output can take a word.
	assign en = !out_v_q || m_tready;
	assign pop = en && !queue_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_v_s1 <= 1'b0;
		end else if (en) begin
			prod_v_s1 <= !queue_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1.lo <= pop_item.lo;
			prod_s1.neg <= pop_item.neg;
			prod_s1.d <= pop_item.d;
			prod_s1.m <= pop_item.dm * pop_item.pa;
		end
	end

	// Numerator and denominator of floor((2n + d) / 2d), with the sign folded out.
	always_comb begin
		two_m = {prod_s1.m, 1'b0};
		d_ext = REM_W'(prod_s1.d);
		prep.lo = prod_s1.lo;
		prep.flat = prod_s1.d == '0;
		prep.den = {prod_s1.d, 1'b0};
		prep.quo = '0;
		if (!prod_s1.neg) begin
			prep.qneg = 1'b0;
			prep.rem = two_m + d_ext;
		end else if (two_m <= d_ext) begin
			prep.qneg = 1'b0;
			prep.rem = d_ext - two_m;
		end else begin
			prep.qneg = 1'b1;
			prep.rem = two_m + d_ext - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v[0] <= 1'b0;
		end else if (en) begin
			div_v[0] <= prod_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0] <= prep;
		end
	end

	for (genvar i = 0; i < QUO_W; i++) begin : g_div
		localparam int B = QUO_W - 1 - i;
		logic [REM_W:0] trial;
		div_t           nxt;

		always_comb begin
			trial = {1'b0, div_s[i].rem} - ((REM_W + 1)'(div_s[i].den) << B);
			nxt = div_s[i];
			if (!trial[REM_W]) begin
				nxt.rem = trial[REM_W-1:0];
				nxt.quo[B] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v[i+1] <= 1'b0;
			end else if (en) begin
				div_v[i+1] <= div_v[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[i+1] <= nxt;
			end
		end
	end

	assign last = div_s[QUO_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= div_v[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (last.flat) begin
				out_q <= last.lo;
			end else if (last.qneg) begin
				out_q <= last.lo - last.quo;
			end else begin
				out_q <= last.lo + last.quo;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = out_q;

endmodule

/* hw/rtl/piecewise_contrast_stretch.sv */
`timescale 1ns / 1ps
// Each accepted word passes the front register, the queue, the product, divider and output stages.
// Throughput: one pixel per cycle while m_tready holds, set by the fully pipelined one-bit-per-stage divider.
// A four-entry queue separates classification from the multiply and divide pipeline.
// Reset (arst_n low, asynchronous) empties all stages and the queue and restores the
// breakpoints to in_low 0, in_high 255, out_low 0, out_high 255.

module piecewise_contrast_stretch (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pcs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pcs_pkg::PIX_W-1:0]       cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [pcs_pkg::PIX_W-1:0]       s_tdata,  // [7:0] pixel_in
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [pcs_pkg::PIX_W-1:0]       m_tdata   // [7:0] pixel_out
);
	import pcs_pkg::*;

	logic  push;
	item_t push_item;
	logic  queue_full;
	logic  pop;
	logic  queue_empty;
	item_t pop_item;

	pcs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.push       (push),
		.push_item  (push_item),
		.queue_full (queue_full)
	);

	pcs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.empty     (queue_empty),
		.pop_item  (pop_item)
	);

	pcs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.pop_item    (pop_item),
		.pop         (pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
	import pcs_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = '1;
	localparam int CYCLE_LIMIT = 200000;
	localparam int FLUSH_CYCLES = 16;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_PIXELS = 160;
	localparam int HOLD_AFTER = 300;
	localparam int HOLD_CYCLES = 80;
	localparam int PLAN_LEN = 44;

	typedef enum bit {ROW_PIX, ROW_CFG} row_kind_t;

	typedef enum int {
		SHAPE_RANDOM, SHAPE_CROSSED, SHAPE_FLAT, SHAPE_EXTREME, SHAPE_RISING, SHAPE_WIDE
	} curve_shape_t;

	typedef struct {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] addr;
		logic [PIX_W-1:0]     value;
		bit                   fixed;
		logic [PIX_W-1:0]     want;
	} plan_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PIX_W-1:0]     cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [PIX_W-1:0]     s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [PIX_W-1:0]     m_tdata;

	logic [PIX_W-1:0] in_low_q = '0;
	logic [PIX_W-1:0] in_high_q = FULL_SCALE;
	logic [PIX_W-1:0] out_low_q = '0;
	logic [PIX_W-1:0] out_high_q = FULL_SCALE;

	logic [PIX_W-1:0] pending_pixels [$];
	int n_errors = 0;
	int n_out = 0;
	int n_cycles = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit no_gaps = 1'b0;
	bit cfg_open = 1'b0;

	plan_row_t plan [0:PLAN_LEN-1] = '{
		'{ROW_PIX, '0, 8'd0, 1'b1, 8'd0},
		'{ROW_PIX, '0, 8'd255, 1'b1, 8'd255},
		'{ROW_PIX, '0, 8'h55, 1'b1, 8'h55},
		'{ROW_PIX, '0, 8'hAA, 1'b1, 8'hAA},
		'{ROW_CFG, REG_IN_LOW, 8'd100, 1'b0, '0},
		'{ROW_CFG, REG_IN_HIGH, 8'd100, 1'b0, '0},
		'{ROW_CFG, REG_OUT_LOW, 8'd50, 1'b0, '0},
		'{ROW_CFG, REG_OUT_HIGH, 8'd200, 1'b0, '0},
		'{ROW_PIX, '0, 8'd100, 1'b1, 8'd50},
		'{ROW_PIX, '0, 8'd99, 1'b0, '0},
		'{ROW_PIX, '0, 8'd101, 1'b0, '0},
		'{ROW_CFG, REG_IN_LOW, 8'd200, 1'b0, '0},
		'{ROW_CFG, REG_IN_HIGH, 8'd50, 1'b0, '0},
		'{ROW_CFG, REG_OUT_LOW, 8'd30, 1'b0, '0},
		'{ROW_CFG, REG_OUT_HIGH, 8'd220, 1'b0, '0},
		'{ROW_PIX, '0, 8'd100, 1'b0, '0},
		'{ROW_PIX, '0, 8'd199, 1'b0, '0},
		'{ROW_PIX, '0, 8'd200, 1'b0, '0},
		'{ROW_PIX, '0, 8'd0, 1'b1, 8'd0},
		'{ROW_PIX, '0, 8'd255, 1'b1, 8'd255},
		'{ROW_CFG, REG_IN_LOW, 8'd64, 1'b0, '0},
		'{ROW_CFG, REG_IN_HIGH, 8'd192, 1'b0, '0},
		'{ROW_CFG, REG_OUT_LOW, 8'd200, 1'b0, '0},
		'{ROW_CFG, REG_OUT_HIGH, 8'd20, 1'b0, '0},
		'{ROW_PIX, '0, 8'd64, 1'b1, 8'd200},
		'{ROW_PIX, '0, 8'd192, 1'b1, 8'd20},
		'{ROW_PIX, '0, 8'd128, 1'b0, '0},
		'{ROW_PIX, '0, 8'd63, 1'b0, '0},
		'{ROW_PIX, '0, 8'd193, 1'b0, '0},
		'{ROW_CFG, REG_UNMAPPED, 8'hFF, 1'b0, '0},
		'{ROW_CFG, REG_OUT_HIGH + 8'd1, 8'd0, 1'b0, '0},
		'{ROW_PIX, '0, 8'd64, 1'b1, 8'd200},
		'{ROW_CFG, REG_IN_LOW, 8'd255, 1'b0, '0},
		'{ROW_CFG, REG_IN_HIGH, 8'd255, 1'b0, '0},
		'{ROW_CFG, REG_OUT_LOW, 8'd0, 1'b0, '0},
		'{ROW_CFG, REG_OUT_HIGH, 8'd255, 1'b0, '0},
		'{ROW_PIX, '0, 8'd255, 1'b1, 8'd0},
		'{ROW_PIX, '0, 8'd254, 1'b0, '0},
		'{ROW_CFG, REG_IN_LOW, 8'd0, 1'b0, '0},
		'{ROW_CFG, REG_IN_HIGH, 8'd0, 1'b0, '0},
		'{ROW_CFG, REG_OUT_LOW, 8'd255, 1'b0, '0},
		'{ROW_CFG, REG_OUT_HIGH, 8'd0, 1'b0, '0},
		'{ROW_PIX, '0, 8'd0, 1'b1, 8'd255},
		'{ROW_PIX, '0, 8'd1, 1'b0, '0}
	};

	piecewise_contrast_stretch u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [PIX_W-1:0] stretch_pixel(input logic [PIX_W-1:0] p);
		int pix, il, ih, lo, hi, a, b, num, den, q;
		pix = int'(p);
		il = int'(in_low_q);
		ih = int'(in_high_q);
		if (pix < il) begin
			lo = 0;
			hi = int'(out_low_q);
			a = 0;
			b = il;
		end else if (pix <= ih) begin
			lo = int'(out_low_q);
			hi = int'(out_high_q);
			a = il;
			b = ih;
		end else begin
			lo = int'(out_high_q);
			hi = int'(FULL_SCALE);
			a = ih;
			b = int'(FULL_SCALE);
		end
		den = b - a;
		if (den <= 0)
			return PIX_W'(lo);
		// Round half up: lo + floor((2n + d) / 2d), the floor taken toward minus infinity
		// so that falling segments round the same way as rising ones.
		num = 2 * (hi - lo) * (pix - a) + den;
		if (num >= 0)
			q = num / (2 * den);
		else
			q = -((-num + 2 * den - 1) / (2 * den));
		return PIX_W'(lo + q);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("cycle %0d: mismatch: %s", n_cycles, msg);
		n_errors++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (FLUSH_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_valid high so that back-to-back writes stream; the next pixel closes it.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PIX_W-1:0] val);
		if (!cfg_open)
			drain();
		cfg_open = 1'b1;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_IN_LOW:   in_low_q = val;
			REG_IN_HIGH:  in_high_q = val;
			REG_OUT_LOW:  out_low_q = val;
			REG_OUT_HIGH: out_high_q = val;
			default: ;
		endcase
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] p, input bit fixed,
			input logic [PIX_W-1:0] want);
		if (cfg_open) begin
			cfg_valid <= 1'b0;
			cfg_open = 1'b0;
		end
		while (!no_gaps && $urandom_range(99) < 6) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= p;
		do @(posedge clk); while (!s_tready);
		pending_pixels.push_back(fixed ? want : stretch_pixel(p));
	endtask

	always @(posedge clk) begin : cycle_limit
		n_cycles++;
		if (n_cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin : pixel_sink
		logic [PIX_W-1:0] want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_pixels.size() == 0) begin
					report_mismatch($sformatf("unexpected pixel word %0d", m_tdata));
				end else begin
					want = pending_pixels.pop_front();
					if (m_tdata !== want)
						report_mismatch($sformatf("pixel %0d: got %0d, want %0d",
							n_out, m_tdata, want));
					n_out++;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && n_out >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= no_gaps || ($urandom_range(99) >= 6);
			end
		end
	end

	initial begin
		logic [PIX_W-1:0] il, ih, ol, oh, p;
		logic [PIX_W-1:0] near_pix [8];
		curve_shape_t shape;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				write_reg(plan[i].addr, plan[i].value);
			else
				send_pixel(plan[i].value, plan[i].fixed, plan[i].want);
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			shape = curve_shape_t'((ph < 6) ? ph : $urandom_range(5));
			il = PIX_W'($urandom_range(255));
			ih = PIX_W'($urandom_range(255));
			ol = PIX_W'($urandom_range(255));
			oh = PIX_W'($urandom_range(255));
			case (shape)
				SHAPE_CROSSED: begin
					il = PIX_W'($urandom_range(255, 1));
					ih = PIX_W'($urandom_range(il - 1, 0));
				end
				SHAPE_FLAT: ih = il;
				SHAPE_EXTREME: begin
					il = $urandom_range(1) ? FULL_SCALE : '0;
					ih = $urandom_range(1) ? FULL_SCALE : '0;
					ol = $urandom_range(1) ? FULL_SCALE : '0;
					oh = $urandom_range(1) ? FULL_SCALE : '0;
				end
				SHAPE_RISING: begin
					il = PIX_W'($urandom_range(254));
					ih = PIX_W'($urandom_range(255, il + 1));
				end
				SHAPE_WIDE: begin
					il = PIX_W'($urandom_range(16));
					ih = PIX_W'($urandom_range(255, 239));
				end
				default: ;
			endcase
			write_reg(REG_IN_LOW, il);
			write_reg(REG_IN_HIGH, ih);
			write_reg(REG_OUT_LOW, ol);
			write_reg(REG_OUT_HIGH, oh);
			write_reg(CFG_IDX_W'(REG_OUT_HIGH + 1 + $urandom_range(251)),
				PIX_W'($urandom_range(255)));
			near_pix = '{il - 8'd1, il, il + 8'd1, ih - 8'd1, ih, ih + 8'd1, '0, FULL_SCALE};
			no_gaps = (ph == 2);
			for (int n = 0; n < PHASE_PIXELS; n++) begin
				if (ph == 4 && n == PHASE_PIXELS / 2)
					drain();
				if ($urandom_range(9) < 7)
					p = PIX_W'($urandom_range(255));
				else
					p = near_pix[$urandom_range(7)];
				send_pixel(p, 1'b0, '0);
			end
		end
		no_gaps = 1'b0;
		drain();

		if (n_errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
